/* sv/dxt_pkg.sv */
// Shared types, constants and arithmetic helpers for the block decoder.
package dxt_pkg;

  typedef enum logic [1:0] {
    ModeDxt1Opaque = 2'd0,
    ModeDxt1Alpha  = 2'd1,
    ModeDxt3       = 2'd2,
    ModeDxt5       = 2'd3
  } dxt_mode_t;

  localparam logic [7:0]  WeightTwoThirds = 8'((2 * 256) / 3);
  localparam logic [7:0]  WeightOneThird  = 8'((1 * 256) / 3);
  localparam logic [7:0]  WeightHalf      = 8'd128;
  localparam logic [7:0]  AlphaOpaque     = 8'd255;
  localparam logic [22:0] Div7Mul         = 23'd2341;
  localparam logic [21:0] Div5Mul         = 22'd1639;
  localparam int          TdataOutWidth   = 136;

  typedef struct packed {
    dxt_mode_t             mode;
    logic [3:0][31:0]      pal;
    logic [7:0][7:0]       apal;
    logic [15:0][1:0]      cidx;
    logic [63:0]           ablk;
  } dxt_block_t;

  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  function automatic logic [7:0] lerp_chan(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] w);
    logic signed [8:0]  d;
    logic signed [17:0] prod;
    d    = $signed({1'b0, c0}) - $signed({1'b0, c1});
    prod = 18'(d) * $signed({10'b0, w});
    return c1 + prod[15:8];
  endfunction

  function automatic logic [23:0] lerp_rgb(input logic [23:0] c0, input logic [23:0] c1,
                                           input logic [7:0] w);
    return {lerp_chan(c0[23:16], c1[23:16], w),
            lerp_chan(c0[15:8], c1[15:8], w),
            lerp_chan(c0[7:0], c1[7:0], w)};
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'b0, x} * Div7Mul;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = {11'b0, x} * Div5Mul;
    return p[20:13];
  endfunction

endpackage

/* sv/dxt_palette.sv */
// Color and alpha palette construction for one compressed block.
module dxt_palette (
  input  dxt_pkg::dxt_mode_t mode,
  input  logic [63:0]        cblk,
  input  logic [63:0]        ablk,
  output dxt_pkg::dxt_block_t blk
);

  logic [15:0] col0;
  logic [15:0] col1;
  logic [23:0] e0;
  logic [23:0] e1;
  logic        dxt1;
  logic        four;
  logic [7:0]  amask;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic [10:0] sum7 [6];
  logic [10:0] sum5 [4];

  assign col0  = cblk[15:0];
  assign col1  = cblk[31:16];
  assign e0    = dxt_pkg::expand565(col0);
  assign e1    = dxt_pkg::expand565(col1);
  assign dxt1  = (mode == dxt_pkg::ModeDxt1Opaque) || (mode == dxt_pkg::ModeDxt1Alpha);
  assign four  = !dxt1 || (col0 > col1);
  assign amask = dxt1 ? dxt_pkg::AlphaOpaque : 8'd0;
  assign a0    = ablk[7:0];
  assign a1    = ablk[15:8];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sum7[k] = 11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k + 1);
    end
    for (int k = 0; k < 4; k++) begin
      sum5[k] = 11'(a0) * 11'(4 - k) + 11'(a1) * 11'(k + 1);
    end
  end

  always_comb begin
    blk.mode   = mode;
    blk.cidx   = cblk[63:32];
    blk.ablk   = ablk;
    blk.pal[0] = {amask, e0};
    blk.pal[1] = {amask, e1};
    if (four) begin
      blk.pal[2] = {amask, dxt_pkg::lerp_rgb(e0, e1, dxt_pkg::WeightTwoThirds)};
      blk.pal[3] = {amask, dxt_pkg::lerp_rgb(e0, e1, dxt_pkg::WeightOneThird)};
    end else begin
      blk.pal[2] = {amask, dxt_pkg::lerp_rgb(e0, e1, dxt_pkg::WeightHalf)};
      blk.pal[3] = (mode == dxt_pkg::ModeDxt1Alpha) ? 32'd0 : {amask, 24'd0};
    end
    blk.apal[0] = a0;
    blk.apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 0; k < 6; k++) begin
        blk.apal[2 + k] = dxt_pkg::div7(sum7[k]);
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        blk.apal[2 + k] = dxt_pkg::div5(sum5[k]);
      end
      blk.apal[6] = 8'd0;
      blk.apal[7] = dxt_pkg::AlphaOpaque;
    end
  end

endmodule

/* sv/dxt_row_emit.sv */
// Decoded block register, row counter and output row register.
module dxt_row_emit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 src_valid,
  output logic                                 src_ready,
  input  dxt_pkg::dxt_block_t                  src,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dxt_pkg::TdataOutWidth-1:0]    m_tdata,
  output logic                                 m_tlast
);

  dxt_pkg::dxt_block_t blk;
  logic                blk_valid;
  logic [1:0]          row_cnt;
  logic                out_valid;
  logic [3:0][31:0]    out_pix;
  logic [1:0]          out_row;
  logic                out_last;
  logic                out_load;
  logic                blk_done;
  logic                blk_load;
  logic [3:0][31:0]    row_pix;
  logic [15:0][3:0]    a4;
  logic [15:0][2:0]    a3idx;

  assign a4    = blk.ablk;
  assign a3idx = blk.ablk[63:16];

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      logic [3:0] p;
      logic [7:0] alpha;
      p = {row_cnt, 2'(x)};
      case (blk.mode)
        dxt_pkg::ModeDxt3: alpha = {a4[p], a4[p]};
        dxt_pkg::ModeDxt5: alpha = blk.apal[a3idx[p]];
        default:           alpha = 8'd0;
      endcase
      row_pix[x] = blk.pal[blk.cidx[p]] | {alpha, 24'd0};
    end
  end

  assign out_load  = blk_valid && (!out_valid || m_tready);
  assign blk_done  = out_load && (row_cnt == 2'd3);
  assign src_ready = !blk_valid || blk_done;
  assign blk_load  = src_valid && src_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      row_cnt   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (blk_load) begin
        blk_valid <= 1'b1;
      end else if (blk_done) begin
        blk_valid <= 1'b0;
      end
      if (out_load) begin
        row_cnt <= row_cnt + 2'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_load) begin
      blk <= src;
    end
    if (out_load) begin
      out_pix  <= row_pix;
      out_row  <= row_cnt;
      out_last <= (row_cnt == 2'd3);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_row, out_pix};

`ifndef SYNTHESIS
  a_row_needs_block: assert property (@(posedge clk) disable iff (rst)
    row_cnt != 2'd0 |-> blk_valid)
    else $error("row counter mid-block without a held block");

  a_load_starts_top: assert property (@(posedge clk) disable iff (rst)
    blk_load |=> blk_valid && row_cnt == 2'd0)
    else $error("new block does not start at the top row");

  a_last_on_row3: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_row == 2'd3)
    else $error("last flag on a row other than the bottom row");
`endif

endmodule

/* sv/dxt_block_decoder_unit.sv */
// Top level of the compressed texture block decoder.
//
//  channel  direction  tdata fields (low bit up)                     other
//  s_*      in         color_block[63:0], alpha_block[127:64]        -
//  m_*      out        pixel_left..pixel_right[127:0], row[129:128]  tlast = last_row
//  cfg_*    in         format_mode[1:0]                              write enable
//
//  One request yields four output rows, issued back to back while m_tready
//  stays high; the decoded block register holds each block until its last row is loaded.
//  A request passes the input, decoded block and output row registers in turn.
//  A new block is taken while the previous block still drains its rows.
//  Reset clears all valid flags and sets format_mode to DXT1 opaque.
module dxt_block_decoder_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [127:0]                         s_tdata,   // color_block, alpha_block
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dxt_pkg::TdataOutWidth-1:0]    m_tdata,   // pixel_left, pixel_second,
                                                          // pixel_third, pixel_right,
                                                          // row_number, zero fill
  output logic                                 m_tlast,
  input  logic                                 cfg_wen,
  input  logic [1:0]                           cfg_wdata  // format_mode
);

  dxt_pkg::dxt_mode_t  mode;
  logic                in_valid;
  logic [63:0]         in_cblk;
  logic [63:0]         in_ablk;
  logic                blk_ready;
  dxt_pkg::dxt_block_t pal_blk;

  assign s_tready = !in_valid || blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= dxt_pkg::ModeDxt1Opaque;
      in_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mode <= dxt_pkg::dxt_mode_t'(cfg_wdata);
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cblk <= s_tdata[63:0];
      in_ablk <= s_tdata[127:64];
    end
  end

  dxt_palette u_palette (
    .mode (mode),
    .cblk (in_cblk),
    .ablk (in_ablk),
    .blk  (pal_blk)
  );

  dxt_row_emit u_row_emit (
    .clk       (clk),
    .rst       (rst),
    .src_valid (in_valid),
    .src_ready (blk_ready),
    .src       (pal_blk),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
